### src/ccsp_pkg.sv
// Package for the ChaCha20 share pair generator.
// Holds the block and configuration types, the cipher constants and the half quarter round.
// No dependencies.
package ccsp_pkg;

    localparam int NUM_STAGES = 40;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;

    localparam logic [1:0] REG_SEED_HIGH    = 2'd0;
    localparam logic [1:0] REG_SEED_LOW     = 2'd1;
    localparam logic [1:0] REG_WIDTH_SELECT = 2'd2;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    localparam logic [3:0][31:0] SIGMA =
        {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
    localparam logic [3:0][31:0] KEY_TWEAK =
        {32'hC3EFE9DB, 32'h9E3779B9, 32'h3C6EF372, 32'hA5A5A5A5};
    localparam logic [2:0][31:0] NONCE =
        {32'h12345678, 32'hFEEDFACE, 32'hDEADBEEF};

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [63:0] seed_high;
        logic [63:0] seed_low;
        logic [1:0]  width_select;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_t;

    // One half of a quarter round: the first half rotates by 16 and 12, the second by 8 and 7.
    function automatic qr_t half_qr(input logic [31:0] a_in, input logic [31:0] b_in,
                                    input logic [31:0] c_in, input logic [31:0] d_in,
                                    input logic late);
        qr_t         res;
        logic [31:0] a_v;
        logic [31:0] b_v;
        logic [31:0] c_v;
        logic [31:0] d_v;
        a_v = a_in + b_in;
        d_v = d_in ^ a_v;
        if (late)
            d_v = {d_v[23:0], d_v[31:24]};
        else
            d_v = {d_v[15:0], d_v[31:16]};
        c_v = c_in + d_v;
        b_v = b_in ^ c_v;
        if (late)
            b_v = {b_v[24:0], b_v[31:25]};
        else
            b_v = {b_v[19:0], b_v[31:20]};
        res.a = a_v;
        res.b = b_v;
        res.c = c_v;
        res.d = d_v;
        return res;
    endfunction

endpackage

### src/ccsp_cfg_regs.sv
// Configuration register file with an APB-style port.
// Depends on ccsp_pkg for the register indexes and the configuration type.
module ccsp_cfg_regs
    import ccsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [63:0] seed_high_reg;
    logic [63:0] seed_low_reg;
    logic [1:0]  width_select_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_high_reg    <= '0;
            seed_low_reg     <= '0;
            width_select_reg <= WIDTH_32;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SEED_HIGH:    seed_high_reg    <= pwdata;
                REG_SEED_LOW:     seed_low_reg     <= pwdata;
                REG_WIDTH_SELECT: width_select_reg <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEED_HIGH:    prdata = seed_high_reg;
            REG_SEED_LOW:     prdata = seed_low_reg;
            REG_WIDTH_SELECT: prdata = {62'd0, width_select_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.seed_high    = seed_high_reg;
    assign cfg.seed_low     = seed_low_reg;
    assign cfg.width_select = width_select_reg;

endmodule

### src/ccsp_round_pipe.sv
// Twenty ChaCha20 rounds as forty register stages, one half quarter round per stage.
// Depends on ccsp_pkg for the block type, the constants and the half quarter round.
module ccsp_round_pipe
    import ccsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] counter,
    input  cfg_t        cfg,
    output logic        out_valid,
    output block_t      out_blk
);

    block_t      blk_in [0:NUM_STAGES];
    logic        vld_in [0:NUM_STAGES];
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;

    assign s0 = cfg.seed_low[31:0];
    assign s1 = cfg.seed_low[63:32];
    assign s2 = cfg.seed_high[31:0];
    assign s3 = cfg.seed_high[63:32];

    always_comb
    begin
        blk_in[0][0]  = SIGMA[0];
        blk_in[0][1]  = SIGMA[1];
        blk_in[0][2]  = SIGMA[2];
        blk_in[0][3]  = SIGMA[3];
        blk_in[0][4]  = s0 ^ KEY_TWEAK[0];
        blk_in[0][5]  = s1 ^ KEY_TWEAK[1];
        blk_in[0][6]  = s2 ^ KEY_TWEAK[2];
        blk_in[0][7]  = s3 ^ KEY_TWEAK[3];
        blk_in[0][8]  = s0 ^ s2;
        blk_in[0][9]  = s1 ^ s3;
        blk_in[0][10] = s0 ^ s3;
        blk_in[0][11] = s1 ^ s2;
        blk_in[0][12] = counter;
        blk_in[0][13] = NONCE[0];
        blk_in[0][14] = NONCE[1];
        blk_in[0][15] = NONCE[2];
    end

    assign vld_in[0] = in_valid;

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        localparam int  RND  = k / 2;
        localparam bit  LATE = (k % 2) == 1;
        localparam int  DSH  = ((RND % 2) == 1) ? 1 : 0;

        block_t blk_next;
        block_t blk_reg;
        logic   vld_reg;

        for (genvar q = 0; q < 4; q++)
        begin : g_qr
            localparam int IA = q;
            localparam int IB = 4 + ((q + DSH) % 4);
            localparam int IC = 8 + ((q + 2 * DSH) % 4);
            localparam int ID = 12 + ((q + 3 * DSH) % 4);

            qr_t qr;

            assign qr = half_qr(blk_in[k][IA], blk_in[k][IB], blk_in[k][IC],
                                blk_in[k][ID], LATE);
            assign blk_next[IA] = qr.a;
            assign blk_next[IB] = qr.b;
            assign blk_next[IC] = qr.c;
            assign blk_next[ID] = qr.d;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else
                vld_reg <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            blk_reg <= blk_next;
        end

        assign blk_in[k+1] = blk_reg;
        assign vld_in[k+1] = vld_reg;
    end

    assign out_valid = vld_in[NUM_STAGES];
    assign out_blk   = blk_in[NUM_STAGES];

endmodule

### src/ccsp_finalize.sv
// Feed-forward of the first four words, width masking and the result register.
// Depends on ccsp_pkg for the block and configuration types and the constants.
module ccsp_finalize
    import ccsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  block_t      in_blk,
    input  cfg_t        cfg,
    output logic        result_valid,
    output logic [63:0] share_a,
    output logic [63:0] share_b
);

    logic        valid_reg;
    logic [63:0] share_a_reg;
    logic [63:0] share_b_reg;
    logic [63:0] share_a_next;
    logic [63:0] share_b_next;
    logic [63:0] mask;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;

    assign w0 = in_blk[0] + SIGMA[0];
    assign w1 = in_blk[1] + SIGMA[1];
    assign w2 = in_blk[2] + SIGMA[2];
    assign w3 = in_blk[3] + SIGMA[3];

    always_comb
    begin
        case (cfg.width_select)
            WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
            WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
            WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
            WIDTH_64: mask = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        share_a_next = {w0, w1} & mask;
        share_b_next = {w2, w3} & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        share_a_reg <= share_a_next;
        share_b_reg <= share_b_next;
    end

    assign result_valid = valid_reg;
    assign share_a      = share_a_reg;
    assign share_b      = share_b_reg;

endmodule

### src/chacha20_share_pair_generator_unit.sv
// Top level of the ChaCha20 share pair generator.
// Depends on ccsp_pkg, ccsp_cfg_regs, ccsp_round_pipe and ccsp_finalize.
//
//   Channel   Signals                                   Handshake
//   input     triple_index                              start while busy is low
//   result    share_a, share_b                          result_valid, one cycle
//   config    psel penable pwrite paddr pwdata prdata   APB, pready always high
//
// One item is accepted every cycle; busy is never raised.
// The result of an item passes through forty half-round stages and one feed-forward stage,
// each registered, before it appears on share_a and share_b with result_valid.
// Reset clears the valid bits of all stages and loads the register reset values.
// The receiver cannot stall, so results leave in acceptance order without holding.
module chacha20_share_pair_generator_unit
    import ccsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       triple_index,
    output logic              result_valid,
    output logic [63:0]       share_a,
    output logic [63:0]       share_b,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t   cfg;
    logic   pipe_valid;
    block_t pipe_blk;

    assign busy = 1'b0;

    ccsp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccsp_round_pipe u_round_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .counter   (triple_index),
        .cfg       (cfg),
        .out_valid (pipe_valid),
        .out_blk   (pipe_blk)
    );

    ccsp_finalize u_finalize (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pipe_valid),
        .in_blk       (pipe_blk),
        .cfg          (cfg),
        .result_valid (result_valid),
        .share_a      (share_a),
        .share_b      (share_b)
    );

endmodule
